### src/ppp_pkg.sv
package ppp_pkg;

    // field and register widths
    localparam int COORD_W   = 21;
    localparam int DIFF_W    = 22;
    localparam int PROD_W    = 43;
    localparam int SUM_W     = 45;
    localparam int VEC_FRAC  = 19;
    localparam int DOT_W     = SUM_W - VEC_FRAC;
    localparam int ZM_W      = 24;
    localparam int SCALE_W   = 24;
    localparam int ZS_W      = ZM_W + SCALE_W;
    localparam int DEN_W     = ZS_W + 1;
    localparam int SCALE_SH  = 16;
    localparam int Q_BITS    = 17;
    localparam int PIX_W     = 16;
    localparam int DEPTH_W   = 21;
    localparam int CFG_W     = 63;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_REG_W = 13;
    localparam int NEAR_W    = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd7;

    // register reset values
    localparam logic [SCALE_W-1:0]   SCALE_RESET  = 24'd65536;
    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd600;
    localparam logic [NEAR_W-1:0]    NEAR_RESET   = 8'd1;

    // visibility and depth traveling beside the dividers
    typedef struct packed {
        logic                vis;
        logic [DEPTH_W-1:0]  depth;
    } side_t;

endpackage

### src/ppp_div.sv
module ppp_div #(
    parameter int NUM_W = 62
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_W-1:0]              num,
    input  logic [ppp_pkg::DEN_W-1:0]     den,
    input  logic                          neg,
    output logic                          out_valid,
    output logic signed [ppp_pkg::PIX_W-1:0] quo
);

    localparam int QB    = ppp_pkg::Q_BITS;
    localparam int DW    = ppp_pkg::DEN_W;
    localparam int REM_W = ((NUM_W > DW + QB) ? NUM_W : DW + QB) + 1;

    logic [REM_W-1:0] rem_reg [0:QB-1];
    logic [DW-1:0]    den_reg [0:QB-1];
    logic [QB-1:0]    q_reg   [0:QB];
    logic             neg_reg [0:QB];
    logic             ovf_reg [0:QB];
    logic             vld_reg [0:QB];

    // entry stage: quotient overflow check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= REM_W'(num) >= (REM_W'(den) << QB);
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        localparam int B = QB - k;
        logic [REM_W-1:0] shd;
        logic             ge;
        logic [QB-1:0]    q_next;

        always_comb
        begin
            shd       = REM_W'(den_reg[k-1]) << B;
            ge        = rem_reg[k-1] >= shd;
            q_next    = q_reg[k-1];
            q_next[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_next;
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QB)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? rem_reg[k-1] - shd : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    // signed saturation of the truncated quotient
    logic [QB:0] mag;
    localparam logic [QB:0] POS_MAX = (QB+1)'((1 << (ppp_pkg::PIX_W - 1)) - 1);
    localparam logic [QB:0] NEG_MAX = (QB+1)'(1 << (ppp_pkg::PIX_W - 1));

    always_comb
    begin
        mag = {ovf_reg[QB], q_reg[QB]};
        if (neg_reg[QB])
        begin
            if (mag > NEG_MAX)
                quo = $signed(ppp_pkg::PIX_W'(NEG_MAX));
            else
                quo = $signed(ppp_pkg::PIX_W'(-mag));
        end
        else
        begin
            if (mag > POS_MAX)
                quo = $signed(ppp_pkg::PIX_W'(POS_MAX));
            else
                quo = $signed(ppp_pkg::PIX_W'(mag));
        end
    end

    assign out_valid = vld_reg[QB];

endmodule

### src/perspective_point_projector_core.sv
// Pinhole camera projector: one signed Q12.8 world point per request on s_tdata, one
// result per point on m_tdata/m_tuser, in order. The camera offset, three dot
// products, scaling multiplies and two 18-stage restoring dividers (an overflow
// check stage and 17 quotient-bit stages) form a single pipeline of 26 register
// stages, so a point is accepted every cycle while the pipe is not held; the whole
// pipeline holds while the output register is full and m_tready is low. Points
// behind the near limit come out with visible low and zero coordinates and
// depth. Camera registers are written through cfg_we/cfg_addr/cfg_data
// and must only change while no point is in flight.
module perspective_point_projector_core #(
    parameter int SCREEN_MAX = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ppp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // world_x [20:0], world_y [41:21], world_z [62:42], zero [63]
    input  logic [63:0]                       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // screen_x [15:0], screen_y [31:16], depth [52:32], zero [55:53]
    output logic [55:0]                       m_tdata,
    // visible [0]
    output logic [0:0]                        m_tuser
);

    localparam int CW   = ppp_pkg::COORD_W;
    localparam int DW   = $clog2(SCREEN_MAX + 1);
    localparam int RH_W = ppp_pkg::DOT_W + DW + 1;
    localparam int WZ_W = ppp_pkg::ZS_W + DW;
    localparam int NW   = WZ_W + 2;
    localparam int QB   = ppp_pkg::Q_BITS;

    // configuration registers
    logic [ppp_pkg::CFG_W-1:0]     pos_reg, fwd_reg, rgt_reg, up_reg;
    logic [ppp_pkg::SCALE_W-1:0]   scale_reg;
    logic [ppp_pkg::DIM_REG_W-1:0] width_reg, height_reg;
    logic [ppp_pkg::NEAR_W-1:0]    near_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fwd_reg    <= '0;
            rgt_reg    <= '0;
            up_reg     <= '0;
            scale_reg  <= ppp_pkg::SCALE_RESET;
            width_reg  <= ppp_pkg::WIDTH_RESET;
            height_reg <= ppp_pkg::HEIGHT_RESET;
            near_reg   <= ppp_pkg::NEAR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ppp_pkg::REG_POSITION: pos_reg    <= cfg_data;
                ppp_pkg::REG_FORWARD:  fwd_reg    <= cfg_data;
                ppp_pkg::REG_RIGHT:    rgt_reg    <= cfg_data;
                ppp_pkg::REG_UP:       up_reg     <= cfg_data;
                ppp_pkg::REG_SCALE:    scale_reg  <= cfg_data[ppp_pkg::SCALE_W-1:0];
                ppp_pkg::REG_WIDTH:    width_reg  <= cfg_data[ppp_pkg::DIM_REG_W-1:0];
                ppp_pkg::REG_HEIGHT:   height_reg <= cfg_data[ppp_pkg::DIM_REG_W-1:0];
                ppp_pkg::REG_NEAR:     near_reg   <= cfg_data[ppp_pkg::NEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective scale and window size
    logic [ppp_pkg::SCALE_W-1:0] scale_eff;
    logic [DW-1:0]               w_eff, h_eff;

    always_comb
    begin
        scale_eff = (scale_reg == '0) ? ppp_pkg::SCALE_W'(1) : scale_reg;
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (32'(width_reg) > SCREEN_MAX)
            w_eff = DW'(SCREEN_MAX);
        else
            w_eff = DW'(width_reg);
        if (height_reg == '0)
            h_eff = DW'(1);
        else if (32'(height_reg) > SCREEN_MAX)
            h_eff = DW'(SCREEN_MAX);
        else
            h_eff = DW'(height_reg);
    end

    // global advance: whole pipe moves unless the output is held
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: offset from camera
    logic                           v1_reg;
    logic signed [ppp_pkg::DIFF_W-1:0] d_reg [0:2];

    // stage 2: nine products, vector j times offset k at 3*j+k
    logic                           v2_reg;
    logic signed [ppp_pkg::PROD_W-1:0] p_reg [0:8];

    // stage 3: depth, right and up offsets
    logic                           v3_reg;
    logic signed [ppp_pkg::DOT_W-1:0]  dot_reg [0:2];

    // stage 4
    logic                           v4_reg;
    ppp_pkg::side_t                 side4_reg;
    logic [ppp_pkg::ZS_W-1:0]       zs4_reg;
    logic signed [RH_W-1:0]         rh4_reg, uh4_reg;

    // stage 5
    logic                           v5_reg;
    ppp_pkg::side_t                 side5_reg;
    logic [ppp_pkg::ZS_W-1:0]       zs5_reg;
    logic [WZ_W-1:0]                wz5_reg, hz5_reg;
    logic signed [RH_W-1:0]         rh5_reg, uh5_reg;

    // stage 6
    logic                           v6_reg;
    ppp_pkg::side_t                 side6_reg;
    logic [ppp_pkg::DEN_W-1:0]      den6_reg;
    logic signed [NW-1:0]           nx6_reg, ny6_reg;

    // stage 7: magnitudes and signs
    logic                           v7_reg;
    logic [ppp_pkg::DEN_W-1:0]      den7_reg;
    logic [NW-2:0]                  mx7_reg, my7_reg;
    logic                           sx7_reg, sy7_reg;

    // side line across the dividers
    ppp_pkg::side_t                 side_reg [0:QB+1];

    // combinational values per stage
    logic signed [ppp_pkg::DIFF_W-1:0] d_next [0:2];
    logic signed [ppp_pkg::SUM_W-1:0]  sum_next [0:2];
    logic signed [ppp_pkg::DOT_W-1:0]  near_ext;
    logic signed [DW:0]                h_s;
    logic                              vis_next;
    logic [ppp_pkg::DEPTH_W-1:0]       dep_next;
    logic signed [NW-1:0]              nx_next, ny_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = ppp_pkg::DIFF_W'($signed(s_tdata[k*CW +: CW]))
                      - ppp_pkg::DIFF_W'($signed(pos_reg[k*CW +: CW]));
        end
        for (int j = 0; j < 3; j++)
        begin
            sum_next[j] = ppp_pkg::SUM_W'(p_reg[3*j])
                        + ppp_pkg::SUM_W'(p_reg[3*j+1])
                        + ppp_pkg::SUM_W'(p_reg[3*j+2]);
        end
        near_ext = $signed(ppp_pkg::DOT_W'(near_reg));
        h_s      = $signed({1'b0, h_eff});
        vis_next = (dot_reg[0] > 0) && (dot_reg[0] >= near_ext);
        if (dot_reg[0] > $signed(ppp_pkg::DOT_W'({ppp_pkg::DEPTH_W{1'b1}})))
            dep_next = '1;
        else
            dep_next = dot_reg[0][ppp_pkg::DEPTH_W-1:0];
        nx_next = $signed(NW'(wz5_reg)) + (NW'(rh5_reg) <<< ppp_pkg::SCALE_SH);
        ny_next = $signed(NW'(hz5_reg)) - (NW'(uh5_reg) <<< ppp_pkg::SCALE_SH);
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                d_reg[k] <= d_next[k];

            for (int k = 0; k < 3; k++)
            begin
                p_reg[k]   <= d_reg[k] * $signed(fwd_reg[k*CW +: CW]);
                p_reg[3+k] <= d_reg[k] * $signed(rgt_reg[k*CW +: CW]);
                p_reg[6+k] <= d_reg[k] * $signed(up_reg[k*CW +: CW]);
            end

            for (int j = 0; j < 3; j++)
                dot_reg[j] <= sum_next[j][ppp_pkg::SUM_W-1:ppp_pkg::VEC_FRAC];

            side4_reg.vis   <= vis_next;
            side4_reg.depth <= dep_next;
            zs4_reg <= dot_reg[0][ppp_pkg::ZM_W-1:0] * scale_eff;
            rh4_reg <= dot_reg[1] * h_s;
            uh4_reg <= dot_reg[2] * h_s;

            side5_reg <= side4_reg;
            zs5_reg   <= zs4_reg;
            wz5_reg   <= zs4_reg * w_eff;
            hz5_reg   <= zs4_reg * h_eff;
            rh5_reg   <= rh4_reg;
            uh5_reg   <= uh4_reg;

            side6_reg <= side5_reg;
            den6_reg  <= {zs5_reg, 1'b0};
            nx6_reg   <= nx_next;
            ny6_reg   <= ny_next;

            side_reg[0] <= side6_reg;
            den7_reg    <= den6_reg;
            sx7_reg     <= nx6_reg[NW-1];
            sy7_reg     <= ny6_reg[NW-1];
            mx7_reg     <= nx6_reg[NW-1] ? (NW-1)'(-nx6_reg) : nx6_reg[NW-2:0];
            my7_reg     <= ny6_reg[NW-1] ? (NW-1)'(-ny6_reg) : ny6_reg[NW-2:0];

            for (int k = 1; k <= QB + 1; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // column and row dividers
    logic                              dvx_vld, dvy_vld;
    logic signed [ppp_pkg::PIX_W-1:0]  qx, qy;

    ppp_div #(.NUM_W(NW - 1)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       (mx7_reg),
        .den       (den7_reg),
        .neg       (sx7_reg),
        .out_valid (dvx_vld),
        .quo       (qx)
    );

    ppp_div #(.NUM_W(NW - 1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .num       (my7_reg),
        .den       (den7_reg),
        .neg       (sy7_reg),
        .out_valid (dvy_vld),
        .quo       (qy)
    );

    // output register
    logic                              vis_out_reg;
    logic signed [ppp_pkg::PIX_W-1:0]  sx_out_reg, sy_out_reg;
    logic [ppp_pkg::DEPTH_W-1:0]       dep_out_reg;
    ppp_pkg::side_t                    side_last;

    assign side_last = side_reg[QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dvx_vld && dvy_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_out_reg <= side_last.vis;
            sx_out_reg  <= side_last.vis ? qx : '0;
            sy_out_reg  <= side_last.vis ? qy : '0;
            dep_out_reg <= side_last.vis ? side_last.depth : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, dep_out_reg, sy_out_reg, sx_out_reg};
    assign m_tuser  = vis_out_reg;

endmodule
